// File: rtl/assert_macros.svh
// Assertion helpers; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QSV_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define QSV_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");
`else
`define QSV_ASSERT(lbl, clk, rst_n, prop)
`define QSV_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// File: rtl/qsv_pkg.sv
package qsv_pkg;

    localparam int MAX_QUBITS_DEF = 10;
    localparam int AMP_BITS_DEF   = 16;

    // round(2^15 / sqrt2)
    localparam int INV_SQRT2_Q15  = 23170;

    typedef enum logic [1:0] {
        MODE_GROUND   = 2'd0,
        MODE_HADAMARD = 2'd1,
        MODE_PAULI_X  = 2'd2,
        MODE_READ     = 2'd3
    } t_mode;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_BAD_QUBIT = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    typedef struct packed {
        logic valid;
        logic sub;
    } t_bfly_ctrl;

endpackage

// File: rtl/qsv_bfly.sv
// Shared butterfly unit: (a +/- b) * 1/sqrt2, rounded and saturated.
// Two-stage pipe: product register, then rounded result register.
module qsv_bfly #(
    parameter int AMP_BITS = qsv_pkg::AMP_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  qsv_pkg::t_bfly_ctrl        i_ctrl,
    input  logic signed [AMP_BITS-1:0] i_a,
    input  logic signed [AMP_BITS-1:0] i_b,
    output logic signed [AMP_BITS-1:0] o_res,
    output logic                       o_valid
);
    import qsv_pkg::*;

    localparam int SW = AMP_BITS + 1;
    localparam int PW = SW + 17;
    localparam logic signed [16:0]   COEF  = 17'(INV_SQRT2_Q15);
    localparam logic signed [PW-1:0] HALF  = PW'(1 << 14);
    localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (AMP_BITS - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

    logic signed [SW-1:0] w_s;
    logic signed [PW-1:0] r_prod;
    logic                 r_pvalid;
    logic signed [PW-1:0] w_q;
    logic signed [PW-1:0] w_sat;

    assign w_s = i_ctrl.sub ? (SW'(i_a) - SW'(i_b)) : (SW'(i_a) + SW'(i_b));

    // floor((p + 2^14) / 2^15): nearest, ties up
    assign w_q = (r_prod + HALF) >>> 15;

    always_comb begin
        w_sat = w_q;
        if (w_q > SAT_HI) begin
            w_sat = SAT_HI;
        end else if (w_q < SAT_LO) begin
            w_sat = SAT_LO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_pvalid <= i_ctrl.valid;
            o_valid  <= r_pvalid;
        end
        r_prod <= PW'(w_s) * PW'(COEF);
        o_res  <= AMP_BITS'(w_sat);
    end

endmodule

// File: rtl/qubit_state_vector_gates_top.sv
// Channel  | Dir | Payload
// s_axis   | in  | tuser: mode; tdata: target_qubit, amp_index
// m_axis   | out | tuser: status; tdata: amp_real, amp_imag
// cfg      | in  | qubits_in_use (4 bits)
//
// Hadamard, per amplitude pair: read, four passes through the two-stage butterfly
// pipe, two writes; 2^(n-1) pairs. Pauli-X: read and two writes per pair.
// Ground-state item: all 2^MAX_QUBITS store entries, one cleared per cycle.
// Read: store read, then result; bad qubit or index: straight to the result.
// After reset the store is cleared the same way (not ready while clearing).
// Input is taken in idle even while a result waits on m_axis.
`include "assert_macros.svh"

module qubit_state_vector_gates_top #(
    parameter int MAX_QUBITS = qsv_pkg::MAX_QUBITS_DEF,
    parameter int AMP_BITS   = qsv_pkg::AMP_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [3:0] target_qubit, [13:4] amp_index
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] amp_real, [31:16] amp_imag
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);
    import qsv_pkg::*;

    localparam int AW    = MAX_QUBITS;
    localparam int DEPTH = 1 << AW;
    localparam int NW    = $clog2(MAX_QUBITS + 1);
    localparam int DW    = 2 * AMP_BITS;
    localparam logic [AMP_BITS-1:0] AMP_ONE = {1'b0, {(AMP_BITS - 1){1'b1}}};

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CLEAR = 7'b0000010,
        S_RD    = 7'b0000100,
        S_CALC  = 7'b0001000,
        S_WR_I  = 7'b0010000,
        S_WR_J  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state           r_state;
    logic [3:0]       r_qubits;
    t_mode            r_mode;
    logic [1:0]       r_status;
    logic             r_item;
    logic [AW-1:0]    r_idx;
    logic [AW-1:0]    r_bit;
    logic [2:0]       r_k;
    logic [2*DW-1:0]  r_new;
    logic [DW-1:0]    r_mem [DEPTH];
    logic [DW-1:0]    r_rd_a;
    logic [DW-1:0]    r_rd_b;
    logic             r_out_valid;
    logic [31:0]      r_out_data;
    logic [1:0]       r_out_user;

    logic [NW-1:0]    w_n;
    logic [AW:0]      w_pairs;
    logic [AW-1:0]    w_pair_last;
    logic [AW-1:0]    w_lmask;
    logic [AW-1:0]    w_i;
    logic [AW-1:0]    w_j;
    logic             w_accept;
    t_mode            w_mode;
    logic [3:0]       w_tq;
    logic [9:0]       w_aidx;
    logic             w_bad_q;
    logic             w_bad_idx;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [DW-1:0]    w_wdata;
    logic [AW-1:0]    w_raddr_a;
    logic             w_out_load;
    t_bfly_ctrl       w_ctrl;
    logic signed [AMP_BITS-1:0] w_op_a;
    logic signed [AMP_BITS-1:0] w_op_b;
    logic signed [AMP_BITS-1:0] w_unit_res;
    logic             w_unit_valid;
    logic signed [31:0] w_re32;
    logic signed [31:0] w_im32;

    // active qubit count, clamped to 1..MAX_QUBITS
    always_comb begin
        if (r_qubits == 4'd0) begin
            w_n = NW'(1);
        end else if (5'({1'b0, r_qubits}) > 5'(MAX_QUBITS)) begin
            w_n = NW'(MAX_QUBITS);
        end else begin
            w_n = NW'(r_qubits);
        end
    end

    assign w_pairs     = (AW + 1)'(1) << (w_n - NW'(1));
    assign w_pair_last = AW'(w_pairs - (AW + 1)'(1));

    // pair index -> lower index: insert a zero at the target bit
    assign w_lmask = r_bit - AW'(1);
    assign w_i     = ((r_idx & ~w_lmask) << 1) | (r_idx & w_lmask);
    assign w_j     = w_i | r_bit;

    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_mode    = t_mode'(s_axis_tuser);
    assign w_tq      = s_axis_tdata[3:0];
    assign w_aidx    = s_axis_tdata[13:4];
    assign w_bad_q   = 5'({1'b0, w_tq}) >= 5'(w_n);
    assign w_bad_idx = 32'(w_aidx) >= (32'd1 << w_n);

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;

    // store write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = (r_idx == '0) ? {{AMP_BITS{1'b0}}, AMP_ONE} : '0;
            end
            S_WR_I: begin
                w_we    = 1'b1;
                w_waddr = w_i;
                w_wdata = (r_mode == MODE_HADAMARD) ? r_new[DW-1:0] : r_rd_b;
            end
            S_WR_J: begin
                w_we    = 1'b1;
                w_waddr = w_j;
                w_wdata = (r_mode == MODE_HADAMARD) ? r_new[2*DW-1:DW] : r_rd_a;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign w_raddr_a = (r_mode == MODE_READ) ? r_idx : w_i;

    // store word: {imag, real}
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (r_state == S_RD) begin
            r_rd_a <= r_mem[w_raddr_a];
            r_rd_b <= r_mem[w_j];
        end
    end

    // k: 0 re sum, 1 im sum, 2 re diff, 3 im diff
    assign w_ctrl.valid = (r_state == S_CALC) && (r_k < 3'd4);
    assign w_ctrl.sub   = r_k[1];
    assign w_op_a = r_k[0] ? signed'(r_rd_a[DW-1:AMP_BITS]) : signed'(r_rd_a[AMP_BITS-1:0]);
    assign w_op_b = r_k[0] ? signed'(r_rd_b[DW-1:AMP_BITS]) : signed'(r_rd_b[AMP_BITS-1:0]);

    qsv_bfly #(
        .AMP_BITS (AMP_BITS)
    ) u_bfly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_a     (w_op_a),
        .i_b     (w_op_b),
        .o_res   (w_unit_res),
        .o_valid (w_unit_valid)
    );

    always_ff @(posedge i_clk) begin
        if (w_unit_valid) begin
            r_new <= {w_unit_res, r_new[2*DW-1:AMP_BITS]};
        end
    end

    assign w_re32 = 32'(signed'(r_rd_a[AMP_BITS-1:0]));
    assign w_im32 = 32'(signed'(r_rd_a[DW-1:AMP_BITS]));

    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_qubits    <= 4'd1;
            r_item      <= 1'b0;
            r_idx       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_GROUND;
            r_status    <= ST_DONE;
            r_bit       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_qubits <= i_cfg_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode   <= w_mode;
                        r_item   <= 1'b1;
                        r_status <= ST_DONE;
                        r_bit    <= AW'(1) << w_tq;
                        r_idx    <= '0;
                        case (w_mode)
                            MODE_GROUND: begin
                                r_state <= S_CLEAR;
                            end
                            MODE_READ: begin
                                r_idx <= AW'(w_aidx);
                                if (w_bad_idx) begin
                                    r_status <= ST_BAD_INDEX;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                            default: begin
                                if (w_bad_q) begin
                                    r_status <= ST_BAD_QUBIT;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_RD;
                                end
                            end
                        endcase
                    end
                end
                S_CLEAR: begin
                    r_idx <= r_idx + AW'(1);
                    if (r_idx == {AW{1'b1}}) begin
                        r_state <= r_item ? S_DONE : S_IDLE;
                    end
                end
                S_RD: begin
                    r_k <= '0;
                    case (r_mode)
                        MODE_READ:     r_state <= S_DONE;
                        MODE_HADAMARD: r_state <= S_CALC;
                        default:       r_state <= S_WR_I;
                    endcase
                end
                S_CALC: begin
                    r_k <= r_k + 3'd1;
                    // last butterfly result lands in r_new this edge
                    if (r_k == 3'd5) begin
                        r_state <= S_WR_I;
                    end
                end
                S_WR_I: begin
                    r_state <= S_WR_J;
                end
                S_WR_J: begin
                    if (r_idx == w_pair_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_RD;
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_item  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_user <= r_status;
            if (r_mode == MODE_READ && r_status == ST_DONE) begin
                r_out_data <= {w_im32[15:0], w_re32[15:0]};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    `QSV_ASSERT_NR(a_boot_busy, i_clk, !i_rst_n |=> !s_axis_tready)
    `QSV_ASSERT(a_busy_after_accept, i_clk, i_rst_n, w_accept |=> !s_axis_tready)
    `QSV_ASSERT(a_unit_in_step, i_clk, i_rst_n, (r_state == S_CALC) && (r_k == 3'd5) |-> w_unit_valid)
    `QSV_ASSERT(a_pair_next, i_clk, i_rst_n, (r_state == S_WR_J) |=> (r_state == S_RD) || (r_state == S_DONE))
    `QSV_ASSERT(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser != ST_DONE) |-> (m_axis_tdata == 32'd0))

endmodule

// File: tb/qsv_checker.sv
`timescale 1ns / 100ps

// Watches the item, result and qubit-count channels, keeps its own copy of the
// state vector and compares every result with the oldest predicted readout.
module qsv_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_in_data,    // [3:0] target_qubit, [13:4] amp_index
    input  logic [1:0]  i_in_user,    // [1:0] mode
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,   // [15:0] amp_real, [31:16] amp_imag
    input  logic [1:0]  i_out_user,   // [1:0] status
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import qsv_pkg::*;

    localparam int STORE_DEPTH = 1 << MAX_QUBITS_DEF;
    localparam int AMP_ONE     = (1 << (AMP_BITS_DEF - 1)) - 1;

    typedef struct packed {
        logic [15:0] re;
        logic [15:0] im;
        logic [1:0]  status;
    } t_readout;

    logic signed [15:0] amp_re [STORE_DEPTH];
    logic signed [15:0] amp_im [STORE_DEPTH];
    logic [3:0]         cfg_qubits;
    t_readout           readout_q [$];
    t_readout           want;
    int                 fails;

    function automatic int active_qubits();
        if (cfg_qubits == 0)
            return 1;
        if (cfg_qubits > MAX_QUBITS_DEF)
            return MAX_QUBITS_DEF;
        return int'(cfg_qubits);
    endfunction

    function automatic void ground_store();
        for (int k = 0; k < STORE_DEPTH; k++) begin
            amp_re[k] = '0;
            amp_im[k] = '0;
        end
        amp_re[0] = 16'(AMP_ONE);
    endfunction

    // (s * round(2^15/sqrt2) + 2^14) >> 15, saturated to 16 bits
    function automatic logic signed [15:0] div_sqrt2(int s);
        longint p;
        p = longint'(s) * INV_SQRT2_Q15;
        p = (p + 64'sd16384) >>> 15;
        if (p > 32767)
            p = 32767;
        if (p < -32768)
            p = -32768;
        return p[15:0];
    endfunction

    function automatic void apply_gate(int tq, bit hadamard);
        int span;
        int step;
        int i;
        int j;
        logic signed [15:0] ar, ai, br, bi;
        span = 1 << active_qubits();
        step = 1 << tq;
        for (i = 0; i < span; i++) begin
            if ((i & step) == 0) begin
                j  = i | step;
                ar = amp_re[i];
                ai = amp_im[i];
                br = amp_re[j];
                bi = amp_im[j];
                if (hadamard) begin
                    amp_re[i] = div_sqrt2(int'(ar) + int'(br));
                    amp_im[i] = div_sqrt2(int'(ai) + int'(bi));
                    amp_re[j] = div_sqrt2(int'(ar) - int'(br));
                    amp_im[j] = div_sqrt2(int'(ai) - int'(bi));
                end else begin
                    amp_re[i] = br;
                    amp_im[i] = bi;
                    amp_re[j] = ar;
                    amp_im[j] = ai;
                end
            end
        end
    endfunction

    function automatic t_readout run_item(t_mode mode, logic [3:0] tq, logic [9:0] idx);
        t_readout r;
        int n;
        r = '{re: '0, im: '0, status: ST_DONE};
        n = active_qubits();
        case (mode)
            MODE_GROUND: begin
                ground_store();
            end
            MODE_HADAMARD, MODE_PAULI_X: begin
                if (int'(tq) >= n)
                    r.status = ST_BAD_QUBIT;
                else
                    apply_gate(int'(tq), mode == MODE_HADAMARD);
            end
            default: begin
                if (int'(idx) >= (1 << n)) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    r.re = amp_re[idx];
                    r.im = amp_im[idx];
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ground_store();
            cfg_qubits = 4'd1;
            readout_q.delete();
            fails = 0;
        end else begin
            // a result never belongs to an item taken at the same edge
            if (i_out_valid && i_out_ready) begin
                if (readout_q.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual re %0d im %0d st %0d",
                             $time, $signed(i_out_data[15:0]), $signed(i_out_data[31:16]),
                             i_out_user);
                    fails++;
                end else begin
                    want = readout_q.pop_front();
                    if (i_out_data[15:0] !== want.re) begin
                        $display("%0t amp_real mismatch: expected %0d actual %0d", $time,
                                 $signed(want.re), $signed(i_out_data[15:0]));
                        fails++;
                    end
                    if (i_out_data[31:16] !== want.im) begin
                        $display("%0t amp_imag mismatch: expected %0d actual %0d", $time,
                                 $signed(want.im), $signed(i_out_data[31:16]));
                        fails++;
                    end
                    if (i_out_user !== want.status) begin
                        $display("%0t status mismatch: expected %0d actual %0d", $time,
                                 want.status, i_out_user);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                cfg_qubits = i_cfg_data;
            if (i_in_valid && i_in_ready)
                readout_q.push_back(run_item(t_mode'(i_in_user), i_in_data[3:0],
                                             i_in_data[13:4]));
        end
        o_fail_count <= fails;
        o_pending    <= readout_q.size();
    end

endmodule

// File: tb/tb_qubit_state_vector_gates_top.sv
`timescale 1ns / 100ps

module tb_qubit_state_vector_gates_top;
    import qsv_pkg::*;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;     // [3:0] target_qubit, [13:4] amp_index
    logic [1:0]  s_axis_tuser  = '0;     // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [15:0] amp_real, [31:16] amp_imag
    logic [1:0]  m_axis_tuser;           // [1:0] status
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data    = '0;

    int fail_count;
    int pending;
    bit idle_en    = 1'b0;
    int active_n   = 1;
    int stall_left = 0;

    int unsigned phase_qubits [8] = '{3, 15, 1, 5, 2, 10, 6, 4};
    int unsigned phase_items  [8] = '{60, 20, 60, 60, 60, 20, 60, 60};

    qubit_state_vector_gates_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    qsv_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result-side stalls: random bursts with m_axis_tready held low
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_item(t_mode mode, logic [3:0] tq, logic [9:0] idx);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {2'b00, idx, tq};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop sending and wait until every predicted readout has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_qubits(logic [3:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        active_n = (value == 0) ? 1 : (value > MAX_QUBITS_DEF) ? MAX_QUBITS_DEF : int'(value);
    endtask

    // mostly in-range gates and reads, a few ground items and bad targets/indexes
    task automatic random_item();
        int unsigned r;
        int          span;
        logic [3:0]  tq;
        logic [9:0]  idx;
        span = 1 << active_n;
        r    = $urandom_range(0, 99);
        tq   = 4'($urandom_range(0, 15));
        idx  = 10'($urandom_range(0, 1023));
        if (r < 6) begin
            send_item(MODE_GROUND, tq, idx);
        end else if (r < 56) begin
            if ($urandom_range(0, 9) == 0)
                tq = 4'($urandom_range(active_n, 15));
            else
                tq = 4'($urandom_range(0, active_n - 1));
            send_item(r < 36 ? MODE_HADAMARD : MODE_PAULI_X, tq, idx);
        end else begin
            if (active_n < MAX_QUBITS_DEF && $urandom_range(0, 9) == 0)
                idx = 10'($urandom_range(span, 1023));
            else
                idx = 10'($urandom_range(0, span - 1));
            send_item(MODE_READ, tq, idx);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one qubit after reset
        send_item(MODE_READ, 4'd15, 10'd0);
        send_item(MODE_READ, 4'd0, 10'd1);
        send_item(MODE_READ, 4'd0, 10'd2);
        send_item(MODE_READ, 4'd0, 10'd1023);
        send_item(MODE_HADAMARD, 4'd0, 10'd1023);
        send_item(MODE_READ, 4'd0, 10'd0);
        send_item(MODE_READ, 4'd0, 10'd1);
        send_item(MODE_PAULI_X, 4'd0, 10'd0);
        send_item(MODE_READ, 4'd0, 10'd1);
        send_item(MODE_HADAMARD, 4'd1, 10'd0);
        send_item(MODE_PAULI_X, 4'd15, 10'd0);

        // full size
        drain();
        write_qubits(4'd10);
        send_item(MODE_GROUND, 4'd15, 10'd1023);
        send_item(MODE_HADAMARD, 4'd9, 10'd0);
        send_item(MODE_PAULI_X, 4'd0, 10'd0);
        send_item(MODE_READ, 4'd0, 10'd513);
        send_item(MODE_READ, 4'd0, 10'd1023);
        send_item(MODE_PAULI_X, 4'd10, 10'd0);
        send_item(MODE_HADAMARD, 4'd15, 10'd0);

        // a count of zero behaves as one qubit
        drain();
        write_qubits(4'd0);
        send_item(MODE_GROUND, 4'd0, 10'd0);
        send_item(MODE_HADAMARD, 4'd0, 10'd0);
        send_item(MODE_HADAMARD, 4'd0, 10'd0);
        send_item(MODE_READ, 4'd0, 10'd0);
        send_item(MODE_READ, 4'd0, 10'd1);
        send_item(MODE_READ, 4'd0, 10'd2);

        for (int p = 0; p < 8; p++) begin
            drain();
            idle_en = (p != 3 && p != 7);
            write_qubits(phase_qubits[p][3:0]);
            send_item(MODE_GROUND, 4'($urandom_range(0, 15)), 10'($urandom_range(0, 1023)));
            repeat (phase_items[p]) random_item();
        end

        drain();
        repeat (1100) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/qsv_pkg.sv
rtl/qsv_bfly.sv
rtl/qubit_state_vector_gates_top.sv
tb/qsv_checker.sv
tb/tb_qubit_state_vector_gates_top.sv
